>>> hdl/bks_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bks_pkg
// Shared types, register codes and saturation helpers for the box smoother.
// ----------------------------------------------------------------------------
package bks_pkg;

  localparam logic [1:0] REG_PROCESS_NOISE     = 2'd0;
  localparam logic [1:0] REG_MEASUREMENT_NOISE = 2'd1;
  localparam logic [1:0] REG_CLAMP_POSITION    = 2'd2;
  localparam logic [1:0] REG_CLAMP_SCALE       = 2'd3;

  localparam logic [30:0] RST_PROCESS_NOISE     = 31'd655;
  localparam logic [30:0] RST_MEASUREMENT_NOISE = 31'd6554;
  localparam logic [30:0] RST_CLAMP_POSITION    = 31'd1310720;
  localparam logic [30:0] RST_CLAMP_SCALE       = 31'd655360;

  localparam logic [1:0] AXIS_CX = 2'd0;
  localparam logic [1:0] AXIS_CY = 2'd1;
  localparam logic [1:0] AXIS_W  = 2'd2;
  localparam logic [1:0] AXIS_H  = 2'd3;

  localparam int NUM_PRODUCTS = 5;

  localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
  localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_LOAD, S_FIRST, S_PRED, S_SCHK, S_KPW, S_KVW,
    S_MUL, S_CLAMP, S_FINAL, S_EMIT
  } state_t;

  typedef struct packed {
    logic       latch;
    logic       load_box;
    logic       first;
    logic       pred;
    logic       schk;
    logic       div_start;
    logic       div_sel;
    logic       kp_latch;
    logic       kv_latch;
    logic       mul_en;
    logic [2:0] mul_k;
    logic       apply_en;
    logic [2:0] apply_k;
    logic       clamp;
    logic       final_stage;
    logic       out_load;
    logic [1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic action;
    logic present;
    logic correct;
    logic started;
    logic s_pos;
    logic div_done;
    logic out_free;
  } stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [31:0] r;
    if (x > SAT_MAX) r = 32'sh7fffffff;
    else if (x < SAT_MIN) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

  function automatic logic signed [65:0] clamp66(input logic signed [65:0] v,
                                                 input logic signed [65:0] lo,
                                                 input logic signed [65:0] hi);
    logic signed [65:0] r;
    if (v < lo) r = lo;
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

endpackage

>>> hdl/bks_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bks_div
// Serial restoring divider for the gains: trunc(num * 2^F / den), saturated.
// ----------------------------------------------------------------------------
module bks_div import bks_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic        [32:0] den,
  output logic               done,
  output logic signed [31:0] quot
);

  localparam int NW = 32 + FRAC_BITS;

  logic [31:0]    num_abs;
  logic [NW-1:0]  mag;
  logic           ovf;
  logic [NW-1:0]  rem;
  logic [62:0]    dsh;
  logic [30:0]    q;
  logic [30:0]    q_next;
  logic [4:0]     cnt;
  logic           busy;
  logic           neg;
  logic [62:0]    rem_ext;
  logic           bit_set;

  assign num_abs = num[31] ? 32'(-num) : 32'(num);
  assign mag     = NW'(num_abs) << FRAC_BITS;
  assign ovf     = 64'(mag) >= {den, 31'd0};
  assign rem_ext = 63'(rem);
  assign bit_set = rem_ext >= dsh;
  assign q_next  = {q[29:0], bit_set};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        neg <= num[31];
        if (ovf) begin
          quot <= num[31] ? 32'sh80000000 : 32'sh7fffffff;
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
          rem  <= mag;
          dsh  <= {den, 30'd0};
          q    <= '0;
          cnt  <= 5'd30;
        end
      end else if (busy) begin
        if (bit_set) rem <= NW'(rem_ext - dsh);
        q   <= q_next;
        dsh <= dsh >> 1;
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
          quot <= neg ? -$signed({1'b0, q_next}) : $signed({1'b0, q_next});
        end
      end
    end
  end

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) || $past(start)))
    else $error("divider done without work");
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    busy |=> !done || !busy)
    else $error("divider busy after done");
  a_busy_clears: assert property (@(posedge clk) disable iff (rst)
    (busy && cnt == 5'd0 && !start) |=> (!busy && done))
    else $error("divider did not finish");

endmodule

>>> hdl/bks_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bks_datapath
// Filter state, shared multiplier, gain divider, clamping and result register.
// ----------------------------------------------------------------------------
module bks_datapath import bks_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output stat_t              st,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               action,
  input  logic               box_present,
  input  logic               measurement_valid,
  input  logic signed [31:0] box_left,
  input  logic signed [31:0] box_top,
  input  logic [30:0]        box_width,
  input  logic [30:0]        box_height,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               result_valid,
  output logic signed [31:0] out_left,
  output logic signed [31:0] out_top,
  output logic signed [31:0] out_width,
  output logic signed [31:0] out_height
);

  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

  logic [30:0] process_noise, measurement_noise, clamp_position, clamp_scale;

  logic               act_r, pres_r, mval_r;
  logic signed [31:0] l_r, t_r;
  logic [30:0]        w_r, h_r;

  logic               started;
  logic signed [31:0] value_r [4];
  logic signed [31:0] rate_r  [4];
  logic signed [31:0] pp_r    [4];
  logic signed [31:0] pv_r    [4];
  logic signed [31:0] vv_r    [4];
  logic signed [31:0] prev_r  [4];

  logic signed [31:0] wa, wb, kp, kv, innov;
  logic        [32:0] s_r;
  logic signed [63:0] prod;
  logic signed [34:0] cx_r, cy_r;
  logic signed [31:0] cw_r, ch_r;

  logic               res_v;
  logic signed [31:0] res_l, res_t, res_w, res_h;

  logic signed [31:0] v_i, r_i, a_i, b_i, c_i, qn, rn;
  logic signed [65:0] sum_v, sum_pp, sum_pv, sum_vv, s_c, z, innov_c;
  logic signed [65:0] load_cx, load_cy;
  logic signed [63:0] sh;
  logic signed [65:0] app;
  logic signed [31:0] mul_a, mul_b;
  logic signed [31:0] div_num;
  logic               div_done;
  logic signed [31:0] div_quot;
  logic signed [65:0] cp_w, cs_w;
  logic signed [65:0] lastx, lasty, cx_c, cy_c, cw_c, ch_c, lc_c, tc_c;

  assign v_i = value_r[cmd.axis];
  assign r_i = rate_r[cmd.axis];
  assign a_i = pp_r[cmd.axis];
  assign b_i = pv_r[cmd.axis];
  assign c_i = vv_r[cmd.axis];
  assign qn  = $signed({1'b0, process_noise});
  assign rn  = $signed({1'b0, measurement_noise});

  assign sum_v  = 66'(v_i) + 66'(r_i);
  assign sum_pp = 66'(a_i) + 66'(b_i) + 66'(b_i) + 66'(c_i) + 66'(qn);
  assign sum_pv = 66'(b_i) + 66'(c_i);
  assign sum_vv = 66'(c_i) + 66'(qn);
  assign s_c    = 66'(a_i) + 66'(rn);

  assign load_cx = 66'(l_r) + 66'($signed({1'b0, w_r[30:1]}));
  assign load_cy = 66'(t_r) + 66'($signed({1'b0, h_r[30:1]}));

  always_comb begin
    case (cmd.axis)
      AXIS_CX: z = load_cx;
      AXIS_CY: z = load_cy;
      AXIS_W:  z = 66'($signed({1'b0, w_r}));
      default: z = 66'($signed({1'b0, h_r}));
    endcase
  end
  assign innov_c = z - 66'(v_i);

  always_comb begin
    case (cmd.mul_k)
      3'd0:    begin mul_a = kp; mul_b = innov; end
      3'd1:    begin mul_a = kv; mul_b = innov; end
      3'd2:    begin mul_a = kp; mul_b = wa;    end
      3'd3:    begin mul_a = kp; mul_b = wb;    end
      default: begin mul_a = kv; mul_b = wb;    end
    endcase
  end

  assign sh = prod >>> FRAC_BITS;
  always_comb begin
    case (cmd.apply_k)
      3'd0:    app = 66'(v_i) + 66'(sh);
      3'd1:    app = 66'(r_i) + 66'(sh);
      3'd2:    app = 66'(wa) - 66'(sh);
      3'd3:    app = 66'(wb) - 66'(sh);
      default: app = 66'(c_i) - 66'(sh);
    endcase
  end

  assign div_num = cmd.div_sel ? wb : a_i;

  bks_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (cmd.div_sel ? s_r : s_c[32:0]),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign cp_w  = 66'($signed({1'b0, clamp_position}));
  assign cs_w  = 66'($signed({1'b0, clamp_scale}));
  assign lastx = 66'(prev_r[0]) + 66'(prev_r[2] >>> 1);
  assign lasty = 66'(prev_r[1]) + 66'(prev_r[3] >>> 1);
  assign cx_c  = clamp66(66'(value_r[0]), lastx - cp_w, lastx + cp_w);
  assign cy_c  = clamp66(66'(value_r[1]), lasty - cp_w, lasty + cp_w);
  assign cw_c  = clamp66(66'(value_r[2]), 66'(prev_r[2]) - cs_w,
                         66'(prev_r[2]) + cs_w);
  assign ch_c  = clamp66(66'(value_r[3]), 66'(prev_r[3]) - cs_w,
                         66'(prev_r[3]) + cs_w);
  assign lc_c  = 66'(cx_r) - 66'(cw_r >>> 1);
  assign tc_c  = 66'(cy_r) - 66'(ch_r >>> 1);

  assign st.action   = act_r;
  assign st.present  = pres_r;
  assign st.correct  = pres_r & mval_r;
  assign st.started  = started;
  assign st.s_pos    = s_c > 66'sd0;
  assign st.div_done = div_done;
  assign st.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise     <= RST_PROCESS_NOISE;
      measurement_noise <= RST_MEASUREMENT_NOISE;
      clamp_position    <= RST_CLAMP_POSITION;
      clamp_scale       <= RST_CLAMP_SCALE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PROCESS_NOISE:     process_noise     <= cfg_data[30:0];
        REG_MEASUREMENT_NOISE: measurement_noise <= cfg_data[30:0];
        REG_CLAMP_POSITION:    clamp_position    <= cfg_data[30:0];
        REG_CLAMP_SCALE:       clamp_scale       <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_r  <= action;
      pres_r <= box_present;
      mval_r <= measurement_valid;
      l_r    <= box_left;
      t_r    <= box_top;
      w_r    <= box_width;
      h_r    <= box_height;
    end
    if (cmd.schk) begin
      s_r   <= s_c[32:0];
      wa    <= a_i;
      wb    <= b_i;
      innov <= sat32(innov_c);
    end
    if (cmd.kp_latch) kp <= div_quot;
    if (cmd.kv_latch) kv <= div_quot;
    if (cmd.mul_en) prod <= 64'(mul_a) * 64'(mul_b);
    if (cmd.clamp) begin
      cx_r <= cx_c[34:0];
      cy_r <= cy_c[34:0];
      cw_r <= sat32(cw_c);
      ch_r <= sat32(ch_c);
    end
    if (cmd.first) begin
      res_v <= pres_r;
      res_l <= pres_r ? l_r : '0;
      res_t <= pres_r ? t_r : '0;
      res_w <= pres_r ? $signed({1'b0, w_r}) : '0;
      res_h <= pres_r ? $signed({1'b0, h_r}) : '0;
    end
    if (cmd.final_stage) begin
      res_v <= 1'b1;
      res_l <= sat32(lc_c);
      res_t <= sat32(tc_c);
      res_w <= cw_r;
      res_h <= ch_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        value_r[i] <= '0;
        rate_r[i]  <= '0;
        pp_r[i]    <= ONE;
        pv_r[i]    <= '0;
        vv_r[i]    <= ONE;
        prev_r[i]  <= '0;
      end
    end else begin
      if (cmd.load_box) begin
        started    <= 1'b1;
        value_r[0] <= sat32(load_cx);
        value_r[1] <= sat32(load_cy);
        value_r[2] <= $signed({1'b0, w_r});
        value_r[3] <= $signed({1'b0, h_r});
        prev_r[0]  <= l_r;
        prev_r[1]  <= t_r;
        prev_r[2]  <= $signed({1'b0, w_r});
        prev_r[3]  <= $signed({1'b0, h_r});
        for (int i = 0; i < 4; i++) begin
          rate_r[i] <= '0;
          pp_r[i]   <= ONE;
          pv_r[i]   <= '0;
          vv_r[i]   <= ONE;
        end
      end
      if (cmd.pred) begin
        value_r[cmd.axis] <= sat32(sum_v);
        pp_r[cmd.axis]    <= sat32(sum_pp);
        pv_r[cmd.axis]    <= sat32(sum_pv);
        vv_r[cmd.axis]    <= sat32(sum_vv);
      end
      if (cmd.apply_en) begin
        case (cmd.apply_k)
          3'd0:    value_r[cmd.axis] <= sat32(app);
          3'd1:    rate_r[cmd.axis]  <= sat32(app);
          3'd2:    pp_r[cmd.axis]    <= sat32(app);
          3'd3:    pv_r[cmd.axis]    <= sat32(app);
          default: vv_r[cmd.axis]    <= sat32(app);
        endcase
      end
      if (cmd.final_stage) begin
        prev_r[0] <= sat32(lc_c);
        prev_r[1] <= sat32(tc_c);
        prev_r[2] <= cw_r;
        prev_r[3] <= ch_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid    <= 1'b1;
      result_valid <= res_v;
      out_left     <= res_l;
      out_top      <= res_t;
      out_width    <= res_w;
      out_height   <= res_h;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  a_load_starts: assert property (@(posedge clk) disable iff (rst)
    cmd.load_box |=> started)
    else $error("load did not mark filter started");
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result overwritten before transfer");
  a_pred_started: assert property (@(posedge clk) disable iff (rst)
    cmd.pred |-> started)
    else $error("predict before filter start");

endmodule

>>> hdl/bks_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bks_ctrl
// Frame sequencer: decode; load a track, or predict and correct each axis, clamp and emit.
// ----------------------------------------------------------------------------
module bks_ctrl import bks_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t st,
  output cmd_t  cmd
);

  state_t     state, state_next;
  logic [1:0] axis, axis_next;
  logic [2:0] k, k_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      axis  <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
      k     <= k_next;
    end
  end

  always_comb begin
    state_next  = state;
    axis_next   = axis;
    k_next      = k;
    cmd         = '0;
    cmd.axis    = axis;
    cmd.mul_k   = k;
    cmd.apply_k = k - 3'd1;
    in_stall    = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        axis_next = '0;
        if (st.action) state_next = st.present ? S_LOAD : S_IDLE;
        else if (!st.started) state_next = S_FIRST;
        else state_next = S_PRED;
      end
      S_LOAD: begin
        cmd.load_box = 1'b1;
        state_next   = S_IDLE;
      end
      S_FIRST: begin
        cmd.first    = 1'b1;
        cmd.load_box = st.present;
        state_next   = S_EMIT;
      end
      S_PRED: begin
        cmd.pred = 1'b1;
        if (st.correct) state_next = S_SCHK;
        else if (axis == AXIS_H) state_next = S_CLAMP;
        else axis_next = axis + 2'd1;
      end
      S_SCHK: begin
        cmd.schk = 1'b1;
        if (st.s_pos) begin
          cmd.div_start = 1'b1;
          state_next    = S_KPW;
        end else if (axis == AXIS_H) begin
          state_next = S_CLAMP;
        end else begin
          axis_next  = axis + 2'd1;
          state_next = S_PRED;
        end
      end
      S_KPW: begin
        if (st.div_done) begin
          cmd.kp_latch  = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = 1'b1;
          state_next    = S_KVW;
        end
      end
      S_KVW: begin
        cmd.div_sel = 1'b1;
        if (st.div_done) begin
          cmd.kv_latch = 1'b1;
          k_next       = '0;
          state_next   = S_MUL;
        end
      end
      S_MUL: begin
        // overlap: multiply product k while writing back product k-1
        cmd.mul_en   = k < 3'(NUM_PRODUCTS);
        cmd.apply_en = k != 3'd0;
        k_next       = k + 3'd1;
        if (k == 3'(NUM_PRODUCTS)) begin
          if (axis == AXIS_H) begin
            state_next = S_CLAMP;
          end else begin
            axis_next  = axis + 2'd1;
            state_next = S_PRED;
          end
        end
      end
      S_CLAMP: begin
        cmd.clamp  = 1'b1;
        state_next = S_FINAL;
      end
      S_FINAL: begin
        cmd.final_stage = 1'b1;
        state_next      = S_EMIT;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall)
    else $error("input taken while busy");
  a_mul_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |-> (k <= 3'(NUM_PRODUCTS)))
    else $error("product counter out of range");
  a_emit_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> (state == S_IDLE))
    else $error("emit did not return to idle");

endmodule

>>> hdl/box_kalman_smoother.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_kalman_smoother
// Constant-velocity Kalman smoothing of a tracked box over four axes.
// ----------------------------------------------------------------------------
// Frame timing: a predict-only frame runs from input transfer to out_valid without
//   the divider; a corrected frame adds the shared serial gain divider (two gains
//   per axis), the shared-multiplier products and the sequencing states per axis.
// Throughput: one frame at a time; the next frame is taken while a result waits.
// Reset (rst, synchronous): filter not started, identity covariance, default
//   noise and clamp registers, no result pending.
module box_kalman_smoother import bks_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               action,
  input  logic               box_present,
  input  logic               measurement_valid,
  input  logic signed [31:0] box_left,
  input  logic signed [31:0] box_top,
  input  logic [30:0]        box_width,
  input  logic [30:0]        box_height,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               result_valid,
  output logic signed [31:0] out_left,
  output logic signed [31:0] out_top,
  output logic signed [31:0] out_width,
  output logic signed [31:0] out_height,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  cmd_t  cmd;
  stat_t st;

  assign cfg_ready = 1'b1;

  bks_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  bks_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .st                (st),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .action            (action),
    .box_present       (box_present),
    .measurement_valid (measurement_valid),
    .box_left          (box_left),
    .box_top           (box_top),
    .box_width         (box_width),
    .box_height        (box_height),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .result_valid      (result_valid),
    .out_left          (out_left),
    .out_top           (out_top),
    .out_width         (out_width),
    .out_height        (out_height)
  );

endmodule

>>> tb/sv/tb_box_kalman_smoother.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_box_kalman_smoother
// Self-checking bench for the box smoother. A software copy of the four-axis
// filter predicts every output box, and the monitor compares each box
// transfer with the oldest prediction. Random idling on both sides, a long
// output hold-off, and register updates between phases.
// ----------------------------------------------------------------------------
module tb_box_kalman_smoother;
  import bks_pkg::*;

  localparam int FB = 16;
  localparam longint ONE = 64'sd1 << FB;

  typedef struct packed {
    logic               action;
    logic               present;
    logic               mvalid;
    logic signed [31:0] left;
    logic signed [31:0] top;
    logic [30:0]        width;
    logic [30:0]        height;
  } frame_t;

  typedef struct packed {
    logic               valid;
    logic signed [31:0] left;
    logic signed [31:0] top;
    logic signed [31:0] width;
    logic signed [31:0] height;
  } box_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  frame_t drv = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic result_valid;
  logic signed [31:0] out_left, out_top, out_width, out_height;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = REG_PROCESS_NOISE;
  logic [31:0] cfg_data = '0;

  // filter copy
  longint q_noise, r_noise, clamp_pos, clamp_scl;
  bit tracking;
  longint val[4], rate[4], cpp[4], cpv[4], cvv[4], last_box[4];

  frame_t pending_frames[$];
  box_t expected_boxes[$];
  int mismatches = 0;
  bit hold_off = 1'b0;
  bit calm = 1'b0;
  bit in_taken = 1'b0;

  box_kalman_smoother #(.FRAC_BITS(FB)) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(drv.action), .box_present(drv.present),
    .measurement_valid(drv.mvalid),
    .box_left(drv.left), .box_top(drv.top),
    .box_width(drv.width), .box_height(drv.height),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_valid(result_valid), .out_left(out_left), .out_top(out_top),
    .out_width(out_width), .out_height(out_height),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint sat(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint fshr(longint x, int n);
    return x >>> n;
  endfunction

  function automatic longint lim(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic load_track(longint l, longint t, longint w, longint h);
    val[0] = sat(l + fshr(w, 1));
    val[1] = sat(t + fshr(h, 1));
    val[2] = w;
    val[3] = h;
    for (int i = 0; i < 4; i++) begin
      rate[i] = 0; cpp[i] = ONE; cpv[i] = 0; cvv[i] = ONE;
    end
    last_box[0] = l; last_box[1] = t; last_box[2] = w; last_box[3] = h;
    tracking = 1'b1;
  endtask

  task automatic reset_filter();
    q_noise = 655; r_noise = 6554; clamp_pos = 1310720; clamp_scl = 655360;
    tracking = 1'b0;
    for (int i = 0; i < 4; i++) begin
      val[i] = 0; rate[i] = 0; cpp[i] = ONE; cpv[i] = 0; cvv[i] = ONE;
      last_box[i] = 0;
    end
  endtask

  task automatic correct_axis(int i, longint z);
    longint a, b, c, s, kp, kv, inn;
    a = cpp[i]; b = cpv[i]; c = cvv[i];
    s = a + r_noise;
    if (s <= 0) return;
    kp = sat((a * ONE) / s);
    kv = sat((b * ONE) / s);
    inn = sat(z - val[i]);
    val[i] = sat(val[i] + fshr(kp * inn, FB));
    rate[i] = sat(rate[i] + fshr(kv * inn, FB));
    cpp[i] = sat(a - fshr(kp * a, FB));
    cpv[i] = sat(b - fshr(kp * b, FB));
    cvv[i] = sat(c - fshr(kv * b, FB));
  endtask

  task automatic predict_box(frame_t f);
    longint l, t, w, h, z[4], a, b, c, lc, cx, cy, cw, ch;
    box_t r;
    l = f.left; t = f.top; w = f.width; h = f.height;
    if (f.action) begin
      if (f.present) load_track(l, t, w, h);
      return;
    end
    if (!tracking) begin
      r = '0;
      if (f.present) begin
        load_track(l, t, w, h);
        r.valid = 1'b1; r.left = f.left; r.top = f.top;
        r.width = {1'b0, f.width}; r.height = {1'b0, f.height};
      end
      expected_boxes.push_back(r);
      return;
    end
    z[0] = l + fshr(w, 1); z[1] = t + fshr(h, 1); z[2] = w; z[3] = h;
    for (int i = 0; i < 4; i++) begin
      a = cpp[i]; b = cpv[i]; c = cvv[i];
      val[i] = sat(val[i] + rate[i]);
      cpp[i] = sat(a + 2 * b + c + q_noise);
      cpv[i] = sat(b + c);
      cvv[i] = sat(c + q_noise);
      if (f.present && f.mvalid) correct_axis(i, z[i]);
    end
    lc = last_box[0] + fshr(last_box[2], 1);
    cx = lim(val[0], lc - clamp_pos, lc + clamp_pos);
    lc = last_box[1] + fshr(last_box[3], 1);
    cy = lim(val[1], lc - clamp_pos, lc + clamp_pos);
    cw = sat(lim(val[2], last_box[2] - clamp_scl, last_box[2] + clamp_scl));
    ch = sat(lim(val[3], last_box[3] - clamp_scl, last_box[3] + clamp_scl));
    last_box[0] = sat(cx - fshr(cw, 1));
    last_box[1] = sat(cy - fshr(ch, 1));
    last_box[2] = cw;
    last_box[3] = ch;
    r.valid = 1'b1;
    r.left = 32'(last_box[0]); r.top = 32'(last_box[1]);
    r.width = 32'(last_box[2]); r.height = 32'(last_box[3]);
    expected_boxes.push_back(r);
  endtask

  // input driver: predict at the transfer edge, update payload on falling edge
  always @(posedge clk) begin
    in_taken = !rst && in_valid && !in_stall;
    if (in_taken) predict_box(drv);
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_frames.size() > 0 && (calm || $urandom_range(99) >= 22)) begin
        in_valid <= 1'b1;
        drv <= pending_frames.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output side
  always @(negedge clk) begin
    out_stall <= hold_off || (!calm && $urandom_range(99) < 22);
  end

  always @(posedge clk) begin
    box_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = {result_valid, out_left, out_top, out_width, out_height};
      if (expected_boxes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected box transfer %h", got);
      end else begin
        want = expected_boxes.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("box mismatch: expected v=%0b %0d %0d %0d %0d got v=%0b %0d %0d %0d %0d",
                     want.valid, want.left, want.top, want.width, want.height,
                     got.valid, got.left, got.top, got.width, got.height);
        end
      end
    end
  end

  function automatic frame_t rand_frame(bit wild);
    frame_t f;
    f.action = ($urandom_range(99) < 4);
    f.present = ($urandom_range(99) < 85);
    f.mvalid = ($urandom_range(99) < 85);
    if (wild) begin
      f.left = $urandom; f.top = $urandom;
      f.width = 31'($urandom); f.height = 31'($urandom);
    end else begin
      f.left = 32'(int'($urandom_range(2000000)) - 1000000) <<< 6;
      f.top = 32'(int'($urandom_range(2000000)) - 1000000) <<< 6;
      f.width = 31'($urandom_range(3000000)) << 4;
      f.height = 31'($urandom_range(3000000)) << 4;
    end
    return f;
  endfunction

  function automatic frame_t mk(bit act, bit pres, bit mv, int l, int t, int w, int h);
    frame_t f;
    f.action = act; f.present = pres; f.mvalid = mv;
    f.left = l; f.top = t; f.width = 31'(w); f.height = 31'(h);
    return f;
  endfunction

  task automatic drain();
    while (pending_frames.size() > 0 || in_valid || expected_boxes.size() > 0)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_PROCESS_NOISE:     q_noise = data[30:0];
      REG_MEASUREMENT_NOISE: r_noise = data[30:0];
      REG_CLAMP_POSITION:    clamp_pos = data[30:0];
      default:               clamp_scl = data[30:0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(int n, int wild_pct);
    for (int k = 0; k < n; k++)
      pending_frames.push_back(rand_frame($urandom_range(99) < wild_pct));
    drain();
  endtask

  initial begin
    reset_filter();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // no box before tracking, first box, reinit, extremes
    pending_frames.push_back(mk(0, 0, 0, 5, 5, 5, 5));
    pending_frames.push_back(mk(1, 0, 1, 7, 7, 7, 7));
    pending_frames.push_back(mk(0, 1, 0, 100 << 16, 50 << 16, 40 << 16, 30 << 16));
    pending_frames.push_back(mk(0, 1, 1, 102 << 16, 51 << 16, 41 << 16, 30 << 16));
    pending_frames.push_back(mk(0, 0, 1, 0, 0, 0, 0));
    pending_frames.push_back(mk(0, 1, 0, 0, 0, 0, 0));
    pending_frames.push_back(mk(0, 1, 1, 32'h7fffffff, 32'h7fffffff,
                                32'h7fffffff, 32'h7fffffff));
    pending_frames.push_back(mk(0, 1, 1, 32'h80000000, 32'h80000000, 0, 0));
    pending_frames.push_back(mk(1, 1, 0, 32'h80000000, 32'h7fffffff,
                                32'h7fffffff, 0));
    pending_frames.push_back(mk(0, 1, 1, 32'h7fffffff, 32'h80000000, 0,
                                32'h7fffffff));
    pending_frames.push_back(mk(1, 1, 1, -5 << 16, 3 << 16, 10 << 16, 12 << 16));
    for (int k = 0; k < 8; k++)
      pending_frames.push_back(mk(0, 1, 1, (-5 + k) << 16, (3 + k) << 16,
                                  (10 + k) << 16, 12 << 16));
    drain();

    // long output hold-off while frames keep coming
    for (int k = 0; k < 20; k++) pending_frames.push_back(rand_frame(0));
    hold_off = 1'b1;
    repeat (3000) @(posedge clk);
    hold_off = 1'b0;
    drain();

    // calm stretch with default settings
    calm = 1'b1;
    random_phase(100, 10);
    calm = 1'b0;
    random_phase(150, 15);

    // extreme settings
    write_reg(REG_PROCESS_NOISE, 32'hffffffff);
    write_reg(REG_MEASUREMENT_NOISE, 32'h7fffffff);
    write_reg(REG_CLAMP_POSITION, 32'h7fffffff);
    write_reg(REG_CLAMP_SCALE, 32'h7fffffff);
    random_phase(120, 30);

    write_reg(REG_PROCESS_NOISE, 32'h0);
    write_reg(REG_MEASUREMENT_NOISE, 32'h1);
    write_reg(REG_CLAMP_POSITION, 32'h0);
    write_reg(REG_CLAMP_SCALE, 32'h0);
    random_phase(120, 30);

    write_reg(REG_PROCESS_NOISE, $urandom_range(65536));
    write_reg(REG_MEASUREMENT_NOISE, 1 + $urandom_range(200000));
    write_reg(REG_CLAMP_POSITION, $urandom_range(1 << 24));
    write_reg(REG_CLAMP_SCALE, $urandom_range(1 << 22));
    random_phase(200, 15);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
